@@ rtl/srts_pkg.sv @@
// Shared constants, status codes and controller/datapath interface types
// for the shortest-route engine. No dependencies.
package srts_pkg;
	localparam int N_NODES = 16;
	localparam int NODE_W  = 4;
	localparam int CNT_W   = 5;
	localparam int COST_W  = 16;
	localparam int PATH_W  = COST_W + 8;
	localparam int ADDR_W  = 2 * NODE_W;
	localparam int LINKS   = N_NODES * N_NODES;

	localparam logic [PATH_W-1:0] INF = {PATH_W{1'b1}};

	localparam logic [1:0] ST_HOP    = 2'd0;
	localparam logic [1:0] ST_NOPATH = 2'd1;
	localparam logic [1:0] ST_BADSRC = 2'd2;

	localparam logic OP_LINK  = 1'b0;
	localparam logic OP_ROUTE = 1'b1;

	typedef struct packed {
		logic       init;
		logic       scan;
		logic       decide;
		logic       walk;
		logic       out_load;
		logic [1:0] out_code;
		logic       emit_dec;
	} cmd_t;

	typedef struct packed {
		logic bad_src;
		logic scan_done;
		logic no_path;
		logic at_sink;
		logic walk_done;
		logic out_last;
	} stat_t;
endpackage

@@ rtl/srts_ctrl.sv @@
// Sequencer for the shortest-route engine: init, settle rounds, walk-back, emit.
// Depends on srts_pkg.
module srts_ctrl import srts_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  op,
	input  logic  out_ready,
	input  stat_t stat,
	output logic  in_ready,
	output logic  out_valid,
	output cmd_t  cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_INIT, S_SCAN, S_DECIDE, S_WALK, S_LOAD, S_SEND
	} state_t;

	state_t     state_q;
	logic [1:0] code_q;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.init     = (state_q == S_INIT);
		cmd.scan     = (state_q == S_SCAN);
		cmd.decide   = (state_q == S_DECIDE);
		cmd.walk     = (state_q == S_WALK);
		cmd.out_load = (state_q == S_LOAD);
		cmd.out_code = code_q;
		cmd.emit_dec = (state_q == S_SEND) && out_ready && !stat.out_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			code_q      <= ST_HOP;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && op == OP_ROUTE) begin
						if (stat.bad_src) begin
							code_q  <= ST_BADSRC;
							state_q <= S_LOAD;
						end else begin
							state_q <= S_INIT;
						end
					end
				end
				S_INIT: state_q <= S_SCAN;
				S_SCAN: begin
					if (stat.scan_done) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (stat.no_path) begin
						code_q  <= ST_NOPATH;
						state_q <= S_LOAD;
					end else if (stat.at_sink) begin
						state_q <= S_WALK;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_WALK: begin
					if (stat.walk_done) begin
						code_q  <= ST_HOP;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_SEND;
				end
				S_SEND: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= stat.out_last ? S_IDLE : S_LOAD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/srts_dp.sv @@
// Datapath: link-cost RAM with per-entry valid bits, path costs, predecessors,
// route buffer and result word registers. Depends on srts_pkg.
module srts_dp import srts_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic               in_fire,
	input  logic               op,
	input  logic [NODE_W-1:0]  source,
	input  logic [NODE_W-1:0]  target,
	input  logic [COST_W-1:0]  link_cost,
	input  logic               cfg_fire,
	input  logic [CNT_W-1:0]   cfg_data,
	output stat_t              stat,
	output logic [NODE_W-1:0]  hop_node,
	output logic [1:0]         status,
	output logic               last
);
	logic [CNT_W-1:0]  node_count_q;
	logic [COST_W-1:0] link_mem [LINKS];
	logic [LINKS-1:0]  link_vld_q;
	logic [COST_W-1:0] link_rd_s1;
	logic              link_vld_s1;

	logic [PATH_W-1:0] path_q [N_NODES];
	logic [NODE_W-1:0] pred_q [N_NODES];
	logic [NODE_W-1:0] route_q [N_NODES];

	logic [NODE_W-1:0] src_q, best_q, next_q, walk_q, eidx_q, idx_s1;
	logic [PATH_W-1:0] here_q, least_q;
	logic [CNT_W-1:0]  idx_q, hops_q;
	logic              s1_v;

	logic [CNT_W-1:0]  n_w;
	logic [NODE_W-1:0] sink_w;
	logic              issue_w;
	logic [ADDR_W-1:0] rd_addr_w;
	logic [COST_W-1:0] c_w;
	logic [PATH_W:0]   sum_w;
	logic [PATH_W-1:0] sat_w, p_w, new_w;
	logic              upd_w;
	logic [NODE_W-1:0] hop_q;
	logic [1:0]        status_q;
	logic              last_q;

	always_comb begin
		if (node_count_q < CNT_W'(2))            n_w = CNT_W'(2);
		else if (node_count_q > CNT_W'(N_NODES)) n_w = CNT_W'(N_NODES);
		else                                     n_w = node_count_q;
	end
	assign sink_w = NODE_W'(n_w - CNT_W'(1));

	assign issue_w   = cmd.scan && (idx_q < n_w);
	assign rd_addr_w = {best_q, idx_q[NODE_W-1:0]};

	// relax stage: the registered link read meets the stored path cost
	assign c_w   = link_vld_s1 ? link_rd_s1 : '0;
	assign sum_w = {1'b0, here_q} + (PATH_W+1)'(c_w);
	assign sat_w = (sum_w > {1'b0, INF}) ? INF : sum_w[PATH_W-1:0];
	assign p_w   = path_q[idx_s1];
	assign upd_w = (idx_s1 != best_q) && (c_w != '0) && (sat_w < p_w);
	always_comb begin
		if (idx_s1 == best_q) new_w = '0;   // settle the current node
		else if (upd_w)       new_w = sat_w;
		else                  new_w = p_w;
	end

	always_comb begin
		stat.bad_src   = ({1'b0, source} >= n_w) || (source == sink_w);
		stat.scan_done = (idx_q >= n_w) && !s1_v;
		stat.no_path   = (least_q == INF);
		stat.at_sink   = (next_q == sink_w);
		stat.walk_done = (walk_q == src_q) || (hops_q >= n_w - CNT_W'(1));
		stat.out_last  = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_W'(N_NODES);
			link_vld_q   <= '0;
			s1_v         <= 1'b0;
		end else begin
			if (cfg_fire) node_count_q <= cfg_data;
			if (in_fire && op == OP_LINK) link_vld_q[{source, target}] <= 1'b1;
			s1_v <= issue_w;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && op == OP_LINK) link_mem[{source, target}] <= link_cost;
		link_rd_s1  <= link_mem[rd_addr_w];
		link_vld_s1 <= link_vld_q[rd_addr_w];
	end

	always_ff @(posedge clk) begin
		if (in_fire) src_q <= source;
		idx_s1 <= idx_q[NODE_W-1:0];
		if (issue_w) idx_q <= idx_q + CNT_W'(1);

		if (cmd.init) begin
			for (int i = 0; i < N_NODES; i++)
				path_q[i] <= (NODE_W'(i) == src_q) ? '0 : INF;
			best_q  <= src_q;
			here_q  <= '0;
			idx_q   <= '0;
			least_q <= INF;
		end else if (s1_v) begin
			path_q[idx_s1] <= new_w;
			if (upd_w) pred_q[idx_s1] <= best_q;
			// strict compare keeps the lowest index among equal costs
			if (new_w != '0 && new_w < least_q) begin
				least_q <= new_w;
				next_q  <= idx_s1;
			end
		end else if (cmd.decide) begin
			best_q  <= next_q;
			here_q  <= least_q;
			idx_q   <= '0;
			least_q <= INF;
			walk_q  <= sink_w;
			hops_q  <= '0;
		end

		if (cmd.walk) begin
			if (!stat.walk_done) begin
				route_q[hops_q[NODE_W-1:0]] <= walk_q;
				hops_q <= hops_q + CNT_W'(1);
				walk_q <= pred_q[walk_q];
			end else begin
				eidx_q <= NODE_W'(hops_q - CNT_W'(1));
			end
		end
		if (cmd.emit_dec) eidx_q <= eidx_q - NODE_W'(1);

		if (cmd.out_load) begin
			status_q <= cmd.out_code;
			if (cmd.out_code == ST_HOP) begin
				hop_q  <= route_q[eidx_q];
				last_q <= (eidx_q == '0);
			end else begin
				hop_q  <= '0;
				last_q <= 1'b1;
			end
		end
	end

	assign hop_node = hop_q;
	assign status   = status_q;
	assign last     = last_q;
endmodule

@@ rtl/shortest_route_to_sink.sv @@
// Shortest route to sink: dense Dijkstra over a 16x16 link-cost RAM.
// Link write: stored on acceptance, block stays idle. Route query: init, then a scan per settle
// round, up to n-1 rounds, then a walk-back over the predecessors from the sink; each result
// word is loaded, then held until out_ready. One query in flight.
// Reset (arst_n, async): all links cleared, node_count = 16, block idle.
module shortest_route_to_sink import srts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              op,
	input  logic [NODE_W-1:0] source,
	input  logic [NODE_W-1:0] target,
	input  logic [COST_W-1:0] link_cost,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [NODE_W-1:0] hop_node,
	output logic [1:0]        status,
	output logic              last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_data
);
	cmd_t  cmd;
	stat_t stat;
	logic  in_fire;

	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;

	srts_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .op, .out_ready, .stat,
		.in_ready, .out_valid, .cmd
	);

	srts_dp u_dp (
		.clk, .arst_n, .cmd, .in_fire, .op, .source, .target, .link_cost,
		.cfg_fire(cfg_valid && cfg_ready), .cfg_data, .stat,
		.hop_node, .status, .last
	);

	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input open while word pending");
	a_stat_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_HOP) |-> last) else $error("status word not last");
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && op == OP_ROUTE) |=> !in_ready) else $error("query not started");
	a_bad_hop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_BADSRC) |-> hop_node == '0) else $error("bad source hop");
endmodule

@@ test/shortest_route_to_sink_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for shortest_route_to_sink: link loads and route queries,
// predicted by a local Dijkstra search. Depends on srts_pkg and the block.
module shortest_route_to_sink_tb;
	import srts_pkg::*;

	typedef struct packed {
		logic [NODE_W-1:0] hop;
		logic [1:0]        code;
		logic              fin;
	} route_word_t;

	typedef struct {
		logic              op;
		logic [NODE_W-1:0] src;
		logic [NODE_W-1:0] dst;
		logic [COST_W-1:0] cost;
		bit                typed;
		logic [1:0]        code;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              op = OP_LINK;
	logic [NODE_W-1:0] source = '0;
	logic [NODE_W-1:0] target = '0;
	logic [COST_W-1:0] link_cost = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [NODE_W-1:0] hop_node;
	logic [1:0]        status;
	logic              last;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CNT_W-1:0]  cfg_data = '0;

	shortest_route_to_sink uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .source(source), .target(target), .link_cost(link_cost),
		.out_valid(out_valid), .out_ready(out_ready),
		.hop_node(hop_node), .status(status), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	logic [COST_W-1:0] cost_mat [N_NODES][N_NODES];
	logic [CNT_W-1:0]  nodes_reg;
	route_word_t       route_q [$];
	int                errors = 0;
	int                idle_cycles = 0;
	bit                quiet = 1'b0;
	bit                hold_off = 1'b0;

	task automatic report(input string what);
		errors++;
		$display("ERROR %0t: %s", $time, what);
	endtask

	// Dense Dijkstra; settled nodes carry cost zero, ties go to lowest index.
	task automatic predict_route(input logic [NODE_W-1:0] src);
		logic [PATH_W-1:0] cost_v [N_NODES];
		logic [NODE_W-1:0] pred [N_NODES];
		logic [NODE_W-1:0] trail [N_NODES];
		logic [PATH_W:0]   sum;
		logic [PATH_W-1:0] least;
		int n, sink, best, cnt, nd;
		n = (nodes_reg < 2) ? 2 : (nodes_reg > N_NODES) ? N_NODES : nodes_reg;
		sink = n - 1;
		if (src >= n || src == sink) begin
			route_q.push_back('{'0, ST_BADSRC, 1'b1});
			return;
		end
		for (int i = 0; i < n; i++) begin
			cost_v[i] = INF;
			pred[i] = '0;
		end
		cost_v[src] = '0;
		best = src;
		for (int r = 0; r < n && best != sink; r++) begin
			least = INF;
			for (int i = 0; i < n; i++) begin
				if (cost_mat[best][i] != 0) begin
					sum = cost_v[best] + cost_mat[best][i];
					if (sum > INF) sum = INF;
					if (sum < cost_v[i]) begin
						cost_v[i] = sum[PATH_W-1:0];
						pred[i] = NODE_W'(best);
					end
				end
			end
			cost_v[best] = '0;
			for (int i = 0; i < n; i++) begin
				if (cost_v[i] > 0 && cost_v[i] < least) begin
					least = cost_v[i];
					best = i;
				end
			end
			if (least == INF) begin
				route_q.push_back('{'0, ST_NOPATH, 1'b1});
				return;
			end
		end
		cnt = 0;
		nd = sink;
		while (nd != src && cnt < n - 1) begin
			trail[cnt++] = NODE_W'(nd);
			nd = pred[nd];
		end
		for (int k = 0; k < cnt; k++)
			route_q.push_back('{trail[cnt-1-k], ST_HOP, k + 1 == cnt});
	endtask

	task automatic send_word(input logic o, input logic [NODE_W-1:0] s,
			input logic [NODE_W-1:0] t, input logic [COST_W-1:0] c);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		source <= s;
		target <= t;
		link_cost <= c;
		do @(posedge clk); while (!in_ready);
		if (o == OP_LINK)
			cost_mat[s][t] = c;
		else
			predict_route(s);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (route_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (600) @(posedge clk);
	endtask

	task automatic write_nodes(input logic [CNT_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		nodes_reg = val;
	endtask

	// Well-formed traffic: mostly link writes, some queries, over a sparse random graph.
	task automatic random_word();
		logic [COST_W-1:0] c;
		c = ($urandom_range(0, 9) == 0) ? COST_W'($urandom) :
			($urandom_range(0, 3) == 0) ? '0 : COST_W'($urandom_range(1, 40));
		if ($urandom_range(0, 2) == 0)
			send_word(OP_ROUTE, NODE_W'($urandom_range(0, 15)), NODE_W'($urandom),
				COST_W'($urandom));
		else
			send_word(OP_LINK, NODE_W'($urandom_range(0, 15)),
				NODE_W'($urandom_range(0, 15)), c);
	endtask

	// Result side: random stalls, one long hold-off on request.
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if (hold_off)
			out_ready <= 1'b0;
		else if (quiet)
			out_ready <= 1'b1;
		else if (out_ready && $urandom_range(0, 5) == 0)
			out_ready <= 1'b0;
		else if (!out_ready && $urandom_range(0, 2) == 0)
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		route_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (route_q.size() == 0) begin
				report($sformatf("unexpected word hop=%0d st=%0d", hop_node, status));
			end else begin
				want = route_q.pop_front();
				if (hop_node !== want.hop)
					report($sformatf("hop_node %0d, want %0d", hop_node, want.hop));
				if (status !== want.code)
					report($sformatf("status %0d, want %0d", status, want.code));
				if (last !== want.fin)
					report($sformatf("last %0b, want %0b", last, want.fin));
			end
		end
	end

	// Watchdog: cycles with no accepted word of any kind.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 100000) begin
			$display("shortest_route_to_sink verification failed");
			$finish;
		end
	end

	stim_row_t rows [$];
	route_word_t got;

	initial begin
		for (int i = 0; i < N_NODES; i++)
			for (int j = 0; j < N_NODES; j++)
				cost_mat[i][j] = '0;
		nodes_reg = 5'd16;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			'{OP_ROUTE, 4'd0, 4'd0, '0, 1'b1, ST_NOPATH},   // empty graph
			'{OP_ROUTE, 4'd15, 4'd0, '0, 1'b1, ST_BADSRC},  // source is sink
			'{OP_LINK, 4'd0, 4'd15, 16'hFFFF, 1'b0, ST_HOP},
			'{OP_LINK, 4'd0, 4'd1, 16'd1, 1'b0, ST_HOP},
			'{OP_LINK, 4'd1, 4'd2, 16'd1, 1'b0, ST_HOP},
			'{OP_LINK, 4'd2, 4'd15, 16'd1, 1'b0, ST_HOP},
			'{OP_ROUTE, 4'd0, 4'hF, 16'hFFFF, 1'b0, ST_HOP},
			'{OP_LINK, 4'd0, 4'd3, 16'd3, 1'b0, ST_HOP},    // tie, lower index
			'{OP_LINK, 4'd3, 4'd15, 16'd1, 1'b0, ST_HOP},
			'{OP_ROUTE, 4'd0, 4'd0, '0, 1'b0, ST_HOP},
			'{OP_LINK, 4'd0, 4'd1, 16'd0, 1'b0, ST_HOP},    // drop a link
			'{OP_ROUTE, 4'd0, 4'd0, '0, 1'b0, ST_HOP},
			'{OP_ROUTE, 4'd14, 4'd0, '0, 1'b1, ST_NOPATH},
			'{OP_LINK, 4'd15, 4'd15, 16'hFFFF, 1'b0, ST_HOP},
			'{OP_ROUTE, 4'd1, 4'd0, '0, 1'b0, ST_HOP}
		};
		foreach (rows[i]) begin
			send_word(rows[i].op, rows[i].src, rows[i].dst, rows[i].cost);
			if (rows[i].typed) begin
				got = route_q[$];
				if (got.code !== rows[i].code)
					report($sformatf("row %0d predicted status %0d", i, got.code));
			end
		end

		// Small graphs and the extremes, with node count outside the range too.
		write_nodes(5'd2);
		send_word(OP_ROUTE, 4'd1, 4'd0, '0);
		send_word(OP_ROUTE, 4'd2, 4'd0, '0);
		send_word(OP_LINK, 4'd0, 4'd1, 16'd7);
		send_word(OP_ROUTE, 4'd0, 4'd0, '0);
		write_nodes(5'd0);
		send_word(OP_ROUTE, 4'd0, 4'd0, '0);
		write_nodes(5'd31);
		send_word(OP_ROUTE, 4'd0, 4'd0, '0);

		for (int ph = 0; ph < 4; ph++) begin
			write_nodes(ph == 0 ? 5'd16 : CNT_W'($urandom_range(2, 17)));
			for (int i = 0; i < 80; i++) random_word();
		end

		// Long receiver hold-off while further queries wait at the input.
		drain();
		hold_off = 1'b1;
		fork
			begin
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 12; i++)
				send_word(OP_ROUTE, NODE_W'($urandom_range(0, 15)), '0, '0);
		join

		write_nodes(5'd16);
		for (int i = 0; i < 60; i++) random_word();
		quiet = 1'b1;
		for (int i = 0; i < 40; i++) random_word();

		drain();
		if (errors == 0 && route_q.size() == 0) begin
			$display("shortest_route_to_sink verification clean");
		end else begin
			$display("shortest_route_to_sink verification failed");
		end
		$finish;
	end
endmodule

@@ files.f @@
rtl/srts_pkg.sv
rtl/srts_ctrl.sv
rtl/srts_dp.sv
rtl/shortest_route_to_sink.sv
test/shortest_route_to_sink_tb.sv
